@@ hdl/qfd_pkg.sv @@
// Shared types, constants and the reciprocal seed table of the Q-format divider.
package qfd_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SEED,
        ST_ITER,
        ST_DONE
    } qfd_state_t;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FRAC_W     = 5;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd15;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 5'd31;

    // Normalizer: shifts of 16, 8, 4, 2, 1
    localparam logic [2:0] NORM_LAST = 3'd4;
    // Multiplier schedule: six Newton products, then the final product
    localparam logic [2:0] ITER_LAST = 3'd6;

    localparam logic [DATA_W-1:0] MIN_NEG  = 32'h8000_0000;
    localparam logic [7:0]        SEED_BASE = 8'h40;
    localparam logic [7:0]        SEED_TOP  = 8'd64;

    // Control from the sequencer to the normalizer
    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] step_idx;
    } norm_ctrl_t;

    // Control from the sequencer to the multiply datapath
    typedef struct packed {
        logic       seed_load;
        logic       mul_en;
        logic [2:0] mul_step;
    } iter_ctrl_t;

    // 7-bit reciprocal seed for a normalized divisor, indexed by d[31:24] - 64
    function automatic logic [6:0] recip_seed(input logic [6:0] idx);
        logic [6:0] s;
        case (idx)
            7'd0:  s = 7'h7F;  7'd1:  s = 7'h7D;  7'd2:  s = 7'h7B;  7'd3:  s = 7'h79;
            7'd4:  s = 7'h78;  7'd5:  s = 7'h76;  7'd6:  s = 7'h74;  7'd7:  s = 7'h73;
            7'd8:  s = 7'h71;  7'd9:  s = 7'h6F;  7'd10: s = 7'h6E;  7'd11: s = 7'h6D;
            7'd12: s = 7'h6B;  7'd13: s = 7'h6A;  7'd14: s = 7'h68;  7'd15: s = 7'h67;
            7'd16: s = 7'h66;  7'd17: s = 7'h65;  7'd18: s = 7'h63;  7'd19: s = 7'h62;
            7'd20: s = 7'h61;  7'd21: s = 7'h60;  7'd22: s = 7'h5F;  7'd23: s = 7'h5E;
            7'd24: s = 7'h5D;  7'd25: s = 7'h5C;  7'd26: s = 7'h5B;  7'd27: s = 7'h5A;
            7'd28: s = 7'h59;  7'd29: s = 7'h58;  7'd30: s = 7'h57;  7'd31: s = 7'h56;
            7'd32: s = 7'h55;  7'd33: s = 7'h54;  7'd34: s = 7'h53;  7'd35: s = 7'h52;
            7'd36: s = 7'h52;  7'd37: s = 7'h51;  7'd38: s = 7'h50;  7'd39: s = 7'h4F;
            7'd40: s = 7'h4E;  7'd41: s = 7'h4E;  7'd42: s = 7'h4D;  7'd43: s = 7'h4C;
            7'd44: s = 7'h4C;  7'd45: s = 7'h4B;  7'd46: s = 7'h4A;  7'd47: s = 7'h49;
            7'd48: s = 7'h49;  7'd49: s = 7'h48;  7'd50: s = 7'h48;  7'd51: s = 7'h47;
            7'd52: s = 7'h46;  7'd53: s = 7'h46;  7'd54: s = 7'h45;  7'd55: s = 7'h45;
            7'd56: s = 7'h44;  7'd57: s = 7'h43;  7'd58: s = 7'h43;  7'd59: s = 7'h42;
            7'd60: s = 7'h42;  7'd61: s = 7'h41;  7'd62: s = 7'h41;  7'd63: s = 7'h40;
            default: s = 7'h40;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/qfd_norm.sv @@
// Divisor normalizer, dividend alignment, overflow check and seed lookup.
module qfd_norm (
    input  logic                          aclk,
    input  qfd_pkg::norm_ctrl_t           ctrl,
    input  logic [qfd_pkg::DATA_W-1:0]    a_mag,
    input  logic [qfd_pkg::DATA_W-1:0]    d_mag,
    input  logic [qfd_pkg::FRAC_W-1:0]    frac_bits,
    output logic [qfd_pkg::DATA_W-1:0]    d_norm,
    output logic [qfd_pkg::DATA_W-1:0]    num_q,
    output logic                          num_ovf,
    output logic [6:0]                    seed
);

    logic [31:0] d_reg, d_next;
    logic [63:0] num_reg, num_next;
    logic [4:0]  sh_amt;
    logic        sh_fits;
    logic [63:0] num_al;
    logic [7:0]  seed_raw;
    logic [6:0]  seed_idx;

    // One binary step of the leading-zero search: shift by 16, 8, 4, 2, 1
    assign sh_amt  = 5'd16 >> ctrl.step_idx;
    assign sh_fits = ((d_reg >> (6'd31 - {1'b0, sh_amt})) == 32'd0);

    always_comb begin
        d_next   = d_reg;
        num_next = num_reg;
        if (ctrl.load) begin
            d_next   = d_mag;
            num_next = {32'd0, a_mag};
        end else if (ctrl.step && sh_fits) begin
            d_next   = d_reg << sh_amt;
            num_next = num_reg << sh_amt;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg   <= d_next;
        num_reg <= num_next;
    end

    // Align dividend to the fraction bits
    always_comb begin
        if (frac_bits == qfd_pkg::FRAC_MAX) begin
            num_al = {num_reg[62:0], 1'b0};
        end else begin
            num_al = num_reg >> (5'd30 - frac_bits);
        end
    end

    assign num_ovf = (num_al[63:32] != 32'd0);
    assign num_q   = num_al[31:0];
    assign d_norm  = d_reg;

    // Seed index from the top byte of the normalized divisor, clamped
    assign seed_raw = d_reg[31:24] - qfd_pkg::SEED_BASE;
    assign seed_idx = (seed_raw > qfd_pkg::SEED_TOP) ? 7'd64 : seed_raw[6:0];
    assign seed     = qfd_pkg::recip_seed(seed_idx);

endmodule

@@ hdl/qfd_iter.sv @@
// Shared 32x32 multiplier running the Newton refinement and the final product.
module qfd_iter (
    input  logic                          aclk,
    input  qfd_pkg::iter_ctrl_t           ctrl,
    input  logic [6:0]                    seed,
    input  logic [qfd_pkg::DATA_W-1:0]    d_norm,
    input  logic [qfd_pkg::DATA_W-1:0]    num_q,
    output logic [qfd_pkg::DATA_W-1:0]    result
);

    logic [31:0] f_reg, f_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [31:0] p31;

    // Operand select: even steps f*d, odd steps f*t, last step f*num
    always_comb begin
        if (ctrl.mul_step == qfd_pkg::ITER_LAST) begin
            op_b = n_reg;
        end else if (ctrl.mul_step[0]) begin
            op_b = t_reg;
        end else begin
            op_b = d_reg;
        end
    end

    assign prod = {32'd0, f_reg} * {32'd0, op_b};
    assign p31  = prod[62:31];

    always_comb begin
        f_next = f_reg;
        d_next = d_reg;
        t_next = t_reg;
        n_next = n_reg;
        if (ctrl.seed_load) begin
            f_next = {1'b0, seed, 24'd0};
            d_next = d_norm;
            n_next = num_q;
        end else if (ctrl.mul_en) begin
            if (ctrl.mul_step == qfd_pkg::ITER_LAST) begin
                t_next = p31;
            end else if (ctrl.mul_step[0]) begin
                f_next = p31;
            end else begin
                // (2^31 - p) << 1 wraps to -(p << 1)
                t_next = 32'd0 - {p31[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        f_reg <= f_next;
        d_reg <= d_next;
        t_reg <= t_next;
        n_reg <= n_next;
    end

    assign result = t_reg;

endmodule

@@ hdl/q_format_divider_unit.sv @@
// Top level of the signed Q-format divider: sequencer, config register, output register.
// Divides two signed 32-bit fixed-point values with frac_bits fraction bits (reset 15) by
// normalizing the divisor, seeding a reciprocal from a 65-entry table and refining it with
// three Newton steps on one shared 32x32 multiplier. An item passes the accept state, the
// leading-zero search, the alignment and seed state, the shared multiplier and the finishing
// state, which rounds off the sign and loads the output register. A zero divisor or a dividend
// of -2^31 goes from the accept state straight to the finishing state, an aligned dividend
// overflow from the seed state. Errors return quotient -1 with error set. The finishing state
// waits for the output side; only then is input taken again, even with a result waiting in the
// output register. frac_bits must be written only while idle; the block does not enforce it.
module q_format_divider_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_dividend,
    input  logic signed [31:0]  s_divisor,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_quotient,
    output logic                m_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_frac_bits
);

    qfd_pkg::qfd_state_t state_reg, state_next;
    logic [2:0]  norm_cnt_reg, norm_cnt_next;
    logic [2:0]  iter_cnt_reg, iter_cnt_next;
    logic        neg_reg, neg_next;
    logic        err_reg, err_next;
    logic [4:0]  frac_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_quotient_reg, m_quotient_next;
    logic        m_error_reg, m_error_next;

    logic        early_err;
    logic [31:0] a_mag, d_mag;
    logic [31:0] d_norm, num_q, result;
    logic        num_ovf;
    logic [6:0]  seed;
    logic        out_free;
    qfd_pkg::norm_ctrl_t norm_ctrl;
    qfd_pkg::iter_ctrl_t iter_ctrl;

    // Config register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= qfd_pkg::FRAC_RESET;
        end else if (cfg_valid) begin
            frac_reg <= cfg_frac_bits;
        end
    end

    // Sign and magnitude split
    assign early_err = (s_divisor == 32'sd0) || (s_dividend == qfd_pkg::MIN_NEG);
    assign a_mag = s_dividend[31] ? (32'd0 - s_dividend) : s_dividend;
    assign d_mag = s_divisor[31]  ? (32'd0 - s_divisor)  : s_divisor;

    assign s_ready  = (state_reg == qfd_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath control
    always_comb begin
        state_next      = state_reg;
        norm_cnt_next   = norm_cnt_reg;
        iter_cnt_next   = iter_cnt_reg;
        neg_next        = neg_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_quotient_next = m_quotient_reg;
        m_error_next    = m_error_reg;
        norm_ctrl       = '0;
        iter_ctrl       = '0;
        case (state_reg)
            qfd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    neg_next = s_dividend[31] ^ s_divisor[31];
                    if (early_err) begin
                        err_next   = 1'b1;
                        state_next = qfd_pkg::ST_DONE;
                    end else begin
                        err_next       = 1'b0;
                        norm_ctrl.load = 1'b1;
                        norm_cnt_next  = 3'd0;
                        state_next     = qfd_pkg::ST_NORM;
                    end
                end
            end
            qfd_pkg::ST_NORM: begin
                norm_ctrl.step     = 1'b1;
                norm_ctrl.step_idx = norm_cnt_reg;
                if (norm_cnt_reg == qfd_pkg::NORM_LAST) begin
                    state_next = qfd_pkg::ST_SEED;
                end else begin
                    norm_cnt_next = norm_cnt_reg + 3'd1;
                end
            end
            qfd_pkg::ST_SEED: begin
                if (num_ovf) begin
                    err_next   = 1'b1;
                    state_next = qfd_pkg::ST_DONE;
                end else begin
                    iter_ctrl.seed_load = 1'b1;
                    iter_cnt_next       = 3'd0;
                    state_next          = qfd_pkg::ST_ITER;
                end
            end
            qfd_pkg::ST_ITER: begin
                iter_ctrl.mul_en   = 1'b1;
                iter_ctrl.mul_step = iter_cnt_reg;
                if (iter_cnt_reg == qfd_pkg::ITER_LAST) begin
                    state_next = qfd_pkg::ST_DONE;
                end else begin
                    iter_cnt_next = iter_cnt_reg + 3'd1;
                end
            end
            qfd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (err_reg || result[31]) begin
                        m_quotient_next = 32'hFFFF_FFFF;
                        m_error_next    = 1'b1;
                    end else begin
                        m_quotient_next = neg_reg ? (32'd0 - result) : result;
                        m_error_next    = 1'b0;
                    end
                    state_next = qfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= qfd_pkg::ST_IDLE;
            norm_cnt_reg <= 3'd0;
            iter_cnt_reg <= 3'd0;
            err_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            norm_cnt_reg <= norm_cnt_next;
            iter_cnt_reg <= iter_cnt_next;
            err_reg      <= err_next;
            neg_reg      <= neg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_quotient_reg <= m_quotient_next;
        m_error_reg    <= m_error_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_quotient = m_quotient_reg;
    assign m_error    = m_error_reg;

    qfd_norm u_norm (
        .aclk      (aclk),
        .ctrl      (norm_ctrl),
        .a_mag     (a_mag),
        .d_mag     (d_mag),
        .frac_bits (frac_reg),
        .d_norm    (d_norm),
        .num_q     (num_q),
        .num_ovf   (num_ovf),
        .seed      (seed)
    );

    qfd_iter u_iter (
        .aclk   (aclk),
        .ctrl   (iter_ctrl),
        .seed   (seed),
        .d_norm (d_norm),
        .num_q  (num_q),
        .result (result)
    );

endmodule

@@ hdl/qfd_checker.sv @@
// Port-level checker for the Q-format divider, bound to the top level.
module qfd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic signed [31:0]  s_dividend,
    input logic signed [31:0]  s_divisor,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_quotient,
    input logic                m_error
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient) && $stable(m_error))
        else $error("result changed while stalled");

    // An error result always carries quotient -1
    a_err_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_quotient == -32'sd1)
        else $error("error result without quotient -1");

    // Busy after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // Zero divisor with a free output goes straight to the finishing state and gives an error result
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && s_divisor == 32'sd0 |=> ##1 (m_valid && m_error))
        else $error("zero divisor not flagged");

endmodule

bind q_format_divider_unit qfd_checker u_qfd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_dividend (s_dividend),
    .s_divisor  (s_divisor),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_quotient (m_quotient),
    .m_error    (m_error)
);

@@ verif/q_format_divider_unit_test.sv @@
// Testbench for the Q-format divider: directed and random divides checked against a predictor.
`timescale 1ns / 1ps

module q_format_divider_unit_test;

    // Cycles without any accepted item before the run is abandoned
    localparam int IDLE_LIMIT = 4000;
    // Cycles the block may still be busy after its last result
    localparam int DRAIN_CYCLES = 32;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int PHASES = 12;
    localparam int MAX_REPORTS = 20;

    typedef struct {
        logic [qfd_pkg::DATA_W-1:0] quotient;
        logic                       error;
    } quot_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [31:0]           s_dividend;
    logic signed [31:0]           s_divisor;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [31:0]           m_quotient;
    logic                         m_error;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [qfd_pkg::FRAC_W-1:0]   cfg_frac_bits;

    // Predictor state and bookkeeping
    logic [qfd_pkg::FRAC_W-1:0] frac_model;
    quot_result_t      expected_q[$];
    logic              steady;
    int                mismatches;
    int                items_sent;
    int                results_seen;
    int                error_results;
    int                cfg_writes;
    int                idle_cycles;

    // Reciprocal seeds, 7-bit values indexed by the top divisor byte minus 64
    logic [7:0] seed_rom [65] = '{
        8'h7F, 8'h7D, 8'h7B, 8'h79, 8'h78, 8'h76, 8'h74, 8'h73,
        8'h71, 8'h6F, 8'h6E, 8'h6D, 8'h6B, 8'h6A, 8'h68, 8'h67,
        8'h66, 8'h65, 8'h63, 8'h62, 8'h61, 8'h60, 8'h5F, 8'h5E,
        8'h5D, 8'h5C, 8'h5B, 8'h5A, 8'h59, 8'h58, 8'h57, 8'h56,
        8'h55, 8'h54, 8'h53, 8'h52, 8'h52, 8'h51, 8'h50, 8'h4F,
        8'h4E, 8'h4E, 8'h4D, 8'h4C, 8'h4C, 8'h4B, 8'h4A, 8'h49,
        8'h49, 8'h48, 8'h48, 8'h47, 8'h46, 8'h46, 8'h45, 8'h45,
        8'h44, 8'h43, 8'h43, 8'h42, 8'h42, 8'h41, 8'h41, 8'h40,
        8'h40
    };

    q_format_divider_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_dividend    (s_dividend),
        .s_divisor     (s_divisor),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quotient    (m_quotient),
        .m_error       (m_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_frac_bits (cfg_frac_bits)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Q31 product: (a*b) >> 31, kept to 32 bits
    function automatic logic [31:0] mul_q31(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'h0, a} * {32'h0, b};
        return p[62:31];
    endfunction

    // One Newton refinement of the reciprocal f of d
    function automatic logic [31:0] newton_step(input logic [31:0] f, input logic [31:0] d);
        logic [31:0] t;
        t = mul_q31(f, d);
        t = 32'h8000_0000 - t;
        t = t << 1;
        return mul_q31(f, t);
    endfunction

    // Expected quotient and error flag for one divide
    function automatic quot_result_t divide_q(input logic [31:0] num_in,
                                              input logic [31:0] den_in,
                                              input logic [qfd_pkg::FRAC_W-1:0] fbits);
        logic [31:0]  a;
        logic [31:0]  d;
        logic [31:0]  numq;
        logic [31:0]  f;
        logic [31:0]  res;
        logic [63:0]  num;
        logic [7:0]   idx;
        logic         neg;
        quot_result_t r;
        r.quotient = '1;
        r.error    = 1'b1;
        if (den_in == '0 || num_in == qfd_pkg::MIN_NEG) return r;
        a   = num_in;
        d   = den_in;
        neg = 1'b0;
        if (d[31]) begin
            neg = 1'b1;
            d   = -d;
        end
        if (a[31]) begin
            neg = !neg;
            a   = -a;
        end
        // normalize the divisor into [2^30, 2^31], dividend follows
        num = {32'h0, a};
        while (d < 32'h4000_0000) begin
            d   = d << 1;
            num = num << 1;
        end
        // align to the Q format
        if (fbits < qfd_pkg::FRAC_MAX) num = num >> (30 - fbits);
        else num = num << 1;
        if (num[63:32] != '0) return r;
        numq = num[31:0];
        idx = d[31:24] - 8'd64;
        if (idx > 8'd64) idx = 8'd64;
        f = {seed_rom[idx[6:0]], 24'h0};
        repeat (3) f = newton_step(f, d);
        res = mul_q31(f, numq);
        if (res > 32'h7FFF_FFFF) return r;
        if (neg) res = -res;
        r.quotient = res;
        r.error    = 1'b0;
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: full random, edge values, and values of random magnitude
    function automatic logic [31:0] pick_operand();
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            v = $urandom();
        end else if (kind < 25) begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = qfd_pkg::MIN_NEG;
                2: v = 32'h7FFF_FFFF;
                3: v = 32'h1;
                4: v = '1;
                default: v = $urandom_range(0, 255);
            endcase
        end else begin
            v = $urandom() >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    // Send one item; returns at the falling edge after it is accepted
    task automatic send_item(input logic [31:0] num, input logic [31:0] den);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_dividend <= num;
        s_divisor  <= den;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(divide_q(num, den, frac_model));
        items_sent++;
        @(negedge aclk);
    endtask

    // Wait until every expected result is in, then let the block settle
    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write frac_bits while the block is idle
    task automatic write_frac(input logic [qfd_pkg::FRAC_W-1:0] value);
        s_valid <= 1'b0;
        wait_drained();
        cfg_valid     <= 1'b1;
        cfg_frac_bits <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        frac_model = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset value of frac_bits and the special operands
    task automatic test_reset_value();
        steady = 1'b1;
        send_item(32'sd32768, 32'sd32768);
        send_item(-32'sd98304, 32'sd65536);
        send_item(32'sd0, -32'sd5);
        send_item(32'sd5, 32'sd0);
        send_item(qfd_pkg::MIN_NEG, 32'sd1);
        send_item(qfd_pkg::MIN_NEG, 32'sd0);
        send_item(32'sd1, qfd_pkg::MIN_NEG);
        send_item(32'h7FFF_FFFF, qfd_pkg::MIN_NEG);
        send_item(32'h7FFF_FFFF, 32'sd1);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(-32'sd1, -32'sd1);
    endtask

    // Extremes of frac_bits: no fraction bits, the left shift, and 30
    task automatic test_frac_extremes();
        steady = 1'b0;
        write_frac(5'd0);
        send_item(32'h7FFF_FFFF, 32'sd1);
        send_item(32'sd7, -32'sd2);
        send_item(-32'sd1, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_frac(qfd_pkg::FRAC_MAX);
        send_item(32'sd1, 32'sd2);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(-32'sd3, qfd_pkg::MIN_NEG);
        write_frac(5'd30);
        send_item(32'sd1 <<< 29, 32'sd1 <<< 30);
        send_item(32'sd0, qfd_pkg::MIN_NEG);
    endtask

    // Random operands across a range of frac_bits settings
    task automatic test_random_values();
        logic [qfd_pkg::FRAC_W-1:0] settings [PHASES];
        settings[0] = 5'd0;
        settings[1] = qfd_pkg::FRAC_MAX;
        settings[2] = qfd_pkg::FRAC_RESET;
        settings[3] = 5'd30;
        settings[4] = 5'd1;
        settings[5] = 5'd16;
        for (int p = 6; p < PHASES; p++) begin
            settings[p] = qfd_pkg::FRAC_W'($urandom_range(0, 31));
        end
        for (int p = 0; p < PHASES; p++) begin
            write_frac(settings[p]);
            // every fourth phase runs without gaps or stalls
            steady = (p % 4 == 3);
            repeat (ITEMS_PER_PHASE) send_item(pick_operand(), pick_operand());
        end
        steady = 1'b0;
    endtask

    // Result side: random stalls on m_ready
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_cnt != 0) begin
                m_ready <= 1'b0;
                stall_cnt--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_cnt = idle_len();
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        quot_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result: quotient %h error %b",
                             $time, m_quotient, m_error);
            end else begin
                exp_r = expected_q.pop_front();
                if (m_error === 1'b1) error_results++;
                if (m_quotient !== exp_r.quotient) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: quotient mismatch: expected %h, actual %h",
                                 $time, exp_r.quotient, m_quotient);
                end
                if (m_error !== exp_r.error) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: error flag mismatch: expected %b, actual %b",
                                 $time, exp_r.error, m_error);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_dividend    = '0;
        s_divisor     = '0;
        cfg_valid     = 1'b0;
        cfg_frac_bits = '0;
        frac_model    = qfd_pkg::FRAC_RESET;
        steady        = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        error_results = 0;
        cfg_writes    = 0;
        idle_cycles   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_value();
        test_frac_extremes();
        test_random_values();

        s_valid <= 1'b0;
        wait_drained();
        if (expected_q.size() != 0) mismatches++;
        $display("Sent %0d divides, checked %0d results (%0d flagged as errors).",
                 items_sent, results_seen, error_results);
        $display("frac_bits was written %0d times, including 0, 30 and 31.", cfg_writes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
